[src/pfi_pkg.sv]
// pfi_pkg: shared types and constants for the printf format interpreter.
// No dependencies; used by every module under src.
package pfi_pkg;

  // ASCII codes the parser and the formatter look for
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_C = 8'h63;
  localparam logic [7:0] CH_LOWER_D = 8'h64;
  localparam logic [7:0] CH_LOWER_I = 8'h69;
  localparam logic [7:0] CH_LOWER_O = 8'h6F;
  localparam logic [7:0] CH_LOWER_U = 8'h75;
  localparam logic [7:0] CH_LOWER_X = 8'h78;

  localparam int unsigned DIGIT_BUFFER = 6;
  localparam int unsigned DIG_IDX_W    = $clog2(DIGIT_BUFFER);
  localparam int unsigned DIG_CNT_W    = $clog2(DIGIT_BUFFER + 1);
  localparam int unsigned WIDTH_W      = 7;   // holds a field width up to 64

  // divide by ten: q = (v * RECIP10) >> RECIP_SHIFT, exact for 16-bit v
  localparam logic [31:0] RECIP10     = 32'd52429;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_HEX,
    RADIX_OCT,
    RADIX_CHR
  } radix_e;

  // decoded command for the item being accepted
  typedef struct packed {
    logic       emit_char;   // copy lit to the output
    logic       convert;     // run a conversion on the argument
    logic [7:0] lit;
    radix_e     radix;
    logic       upper;       // hex letters in upper case
    logic       is_signed;   // d / i
  } cmd_t;

  // spec flags held by the parser
  typedef struct packed {
    logic               zero_pad;
    logic               left_justify;
    logic [WIDTH_W-1:0] pad_width;
  } spec_t;

endpackage

[src/pfi_parser.sv]
// pfi_parser: format string parser, holds the conversion spec state.
// Depends on pfi_pkg.
module pfi_parser #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    format_char_i,
  input  logic          done_i,       // conversion output finished
  output pfi_pkg::cmd_t cmd_o,
  output pfi_pkg::spec_t spec_o
);

  localparam int unsigned CALC_W = pfi_pkg::WIDTH_W + 4;

  logic                        in_spec_q, in_spec_d;
  logic                        zero_pad_q, zero_pad_d;
  logic                        digit_seen_q, digit_seen_d;
  logic                        left_q, left_d;
  logic [pfi_pkg::WIDTH_W-1:0] width_q, width_d;
  logic [CALC_W-1:0]           width_calc;
  logic [pfi_pkg::WIDTH_W-1:0] width_sat;

  // width * 10 + digit, then saturate
  assign width_calc = ({4'b0, width_q} << 3) + ({4'b0, width_q} << 1)
                    + CALC_W'(format_char_i - pfi_pkg::CH_ZERO);
  assign width_sat  = (width_calc > CALC_W'(MAX_WIDTH)) ?
                      pfi_pkg::WIDTH_W'(MAX_WIDTH) : width_calc[pfi_pkg::WIDTH_W-1:0];

  always_comb begin
    in_spec_d    = in_spec_q;
    zero_pad_d   = zero_pad_q;
    digit_seen_d = digit_seen_q;
    left_d       = left_q;
    width_d      = width_q;
    cmd_o        = '0;
    cmd_o.radix  = pfi_pkg::RADIX_DEC;
    if (done_i) begin
      in_spec_d    = 1'b0;
      zero_pad_d   = 1'b0;
      digit_seen_d = 1'b0;
      left_d       = 1'b0;
      width_d      = '0;
    end else if (accept_i) begin
      if (format_char_i == pfi_pkg::CH_NUL) begin
        in_spec_d    = 1'b0;
        zero_pad_d   = 1'b0;
        digit_seen_d = 1'b0;
        left_d       = 1'b0;
        width_d      = '0;
      end else if (!in_spec_q) begin
        if (format_char_i == pfi_pkg::CH_PERCENT) begin
          in_spec_d    = 1'b1;
          zero_pad_d   = 1'b0;
          digit_seen_d = 1'b0;
          left_d       = 1'b0;
          width_d      = '0;
        end else begin
          cmd_o.emit_char = 1'b1;
          cmd_o.lit       = format_char_i;
        end
      end else if (format_char_i == pfi_pkg::CH_ZERO && !digit_seen_q) begin
        zero_pad_d   = 1'b1;
        digit_seen_d = 1'b1;
      end else if (format_char_i inside {[pfi_pkg::CH_ZERO:pfi_pkg::CH_NINE]}) begin
        width_d      = width_sat;
        digit_seen_d = 1'b1;
      end else if (format_char_i == pfi_pkg::CH_MINUS) begin
        left_d = 1'b1;
      end else if (format_char_i == pfi_pkg::CH_PERCENT) begin
        cmd_o.emit_char = 1'b1;
        cmd_o.lit       = pfi_pkg::CH_PERCENT;
        in_spec_d       = 1'b0;
        zero_pad_d      = 1'b0;
        digit_seen_d    = 1'b0;
        left_d          = 1'b0;
        width_d         = '0;
      end else begin
        // spec stays open until the formatter raises done_i
        case (format_char_i)
          pfi_pkg::CH_LOWER_D, pfi_pkg::CH_LOWER_I: begin
            cmd_o.convert   = 1'b1;
            cmd_o.is_signed = 1'b1;
          end
          pfi_pkg::CH_LOWER_U: begin
            cmd_o.convert = 1'b1;
          end
          pfi_pkg::CH_LOWER_X: begin
            cmd_o.convert = 1'b1;
            cmd_o.radix   = pfi_pkg::RADIX_HEX;
          end
          pfi_pkg::CH_UPPER_X: begin
            cmd_o.convert = 1'b1;
            cmd_o.radix   = pfi_pkg::RADIX_HEX;
            cmd_o.upper   = 1'b1;
          end
          pfi_pkg::CH_LOWER_O: begin
            cmd_o.convert = 1'b1;
            cmd_o.radix   = pfi_pkg::RADIX_OCT;
          end
          pfi_pkg::CH_LOWER_C: begin
            cmd_o.convert = 1'b1;
            cmd_o.radix   = pfi_pkg::RADIX_CHR;
          end
          default: begin
            // unknown conversion: drop the spec
            in_spec_d    = 1'b0;
            zero_pad_d   = 1'b0;
            digit_seen_d = 1'b0;
            left_d       = 1'b0;
            width_d      = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_spec_q    <= 1'b0;
      zero_pad_q   <= 1'b0;
      digit_seen_q <= 1'b0;
      left_q       <= 1'b0;
      width_q      <= '0;
    end else begin
      in_spec_q    <= in_spec_d;
      zero_pad_q   <= zero_pad_d;
      digit_seen_q <= digit_seen_d;
      left_q       <= left_d;
      width_q      <= width_d;
    end
  end

  assign spec_o.zero_pad     = zero_pad_q;
  assign spec_o.left_justify = left_q;
  assign spec_o.pad_width    = width_q;

endmodule

[src/pfi_digit_unit.sv]
// pfi_digit_unit: one radix step, quotient and ASCII digit of the remainder.
// Depends on pfi_pkg.
module pfi_digit_unit (
  input  logic            [15:0] val_i,
  input  pfi_pkg::radix_e        radix_i,
  input  logic                   upper_i,
  output logic            [15:0] quo_o,
  output logic            [7:0]  digit_o
);

  logic [31:0] prod;
  logic [15:0] q10;
  logic [15:0] r10;
  logic [3:0]  rem;

  // reciprocal multiply, then remainder by shift-add of q * 10
  assign prod = 32'(val_i) * pfi_pkg::RECIP10;
  assign q10  = 16'(prod >> pfi_pkg::RECIP_SHIFT);
  assign r10  = val_i - ((q10 << 3) + (q10 << 1));

  always_comb begin
    case (radix_i)
      pfi_pkg::RADIX_DEC: begin
        quo_o = q10;
        rem   = r10[3:0];
      end
      pfi_pkg::RADIX_HEX: begin
        quo_o = val_i >> 4;
        rem   = val_i[3:0];
      end
      pfi_pkg::RADIX_OCT: begin
        quo_o = val_i >> 3;
        rem   = {1'b0, val_i[2:0]};
      end
      default: begin
        quo_o = '0;
        rem   = '0;
      end
    endcase
  end

  assign digit_o = (rem <= 4'd9) ? (pfi_pkg::CH_ZERO + {4'b0, rem}) :
                   ((upper_i ? pfi_pkg::CH_UPPER_A : pfi_pkg::CH_LOWER_A)
                    + {4'b0, rem} - 8'd10);

endmodule

[src/printf_format_interpreter_top.sv]
// printf_format_interpreter_top: streaming printf-style formatter.
// Depends on pfi_pkg, pfi_parser and pfi_digit_unit.
//
//   channel   | dir | tdata (low bit up)                    | tuser | tlast
//   ----------+-----+---------------------------------------+-------+-----------------
//   s_axis    | in  | format_char[7:0], argument[23:8]      | -     | -
//   m_axis    | out | out_char[7:0]                         | -     | last char of item
//
// Sequence: an item that emits nothing leaves the sequencer idle (ready again at once).
// A plain character or %% passes through S_CHR. A conversion runs D digit steps
// in S_DIG (none for %c, else 1..6) through the shared digit unit, sets up
// padding in S_PREP, then sends N output characters from S_EMIT at one per cycle
// while m_axis is not stalled, through the single output register. N is
// max(width, digits + sign), at most 64.
// Reset: asynchronous, active low; clears parser flags and the sequencer,
// no clearing pass. Stalls on m_axis hold S_CHR and S_EMIT; s_axis is ready only
// while the sequencer is idle, which includes while a final char waits.
module printf_format_interpreter_top #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // format_char[7:0], argument[23:8]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // out_char[7:0]
  output logic        m_axis_tlast_o
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHR  = 3'd1;   // one literal char
  localparam logic [2:0] S_DIG  = 3'd2;   // digit extraction, lsd first
  localparam logic [2:0] S_PREP = 3'd3;   // pad and length setup
  localparam logic [2:0] S_EMIT = 3'd4;   // sign, pad and digits out

  localparam int unsigned WW = pfi_pkg::WIDTH_W;
  localparam int unsigned CW = pfi_pkg::DIG_CNT_W;
  localparam int unsigned IW = pfi_pkg::DIG_IDX_W;

  logic [2:0]            state_q, state_d;
  logic                  accept;
  logic                  load_ok;
  logic                  done;
  pfi_pkg::cmd_t         cmd;
  pfi_pkg::spec_t        spec;

  logic [7:0]            format_char;
  logic [15:0]           argument;

  // working registers of the conversion
  logic [7:0]            lit_q;
  logic [15:0]           val_q;
  pfi_pkg::radix_e       radix_q;
  logic                  upper_q;
  logic                  neg_q;
  logic                  sign_q;   // sign still to emit
  logic [CW-1:0]         size_q;   // digits produced
  logic [CW-1:0]         k_q;      // digits still to emit
  logic [WW-1:0]         pad_q;    // pad chars still to emit
  logic [WW-1:0]         rem_q;    // chars still to emit
  logic [7:0]            dig_q [pfi_pkg::DIGIT_BUFFER];

  logic [15:0]           quo;
  logic [7:0]            digit_char;
  logic [WW-1:0]         size_ext;
  logic [IW-1:0]         rd_idx;
  logic [7:0]            pad_char;
  logic [7:0]            emit_char;
  logic                  take_sign, take_pad, take_dig;

  // output register
  logic                  out_valid_q;
  logic [7:0]            out_data_q;
  logic                  out_last_q;

  assign format_char = s_axis_tdata_i[7:0];
  assign argument    = s_axis_tdata_i[23:8];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign load_ok         = !out_valid_q || m_axis_tready_i;
  assign done            = (state_q == S_EMIT) && load_ok && (rem_q == WW'(1));

  pfi_parser #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .format_char_i (format_char),
    .done_i        (done),
    .cmd_o         (cmd),
    .spec_o        (spec)
  );

  pfi_digit_unit u_digit (
    .val_i   (val_q),
    .radix_i (radix_q),
    .upper_i (upper_q),
    .quo_o   (quo),
    .digit_o (digit_char)
  );

  assign size_ext = WW'(size_q);
  assign rd_idx   = IW'(k_q - CW'(1));
  assign pad_char = (spec.zero_pad && !spec.left_justify) ? pfi_pkg::CH_ZERO
                                                          : pfi_pkg::CH_SPACE;

  // which piece goes out next, by justification mode
  always_comb begin
    take_sign = 1'b0;
    take_pad  = 1'b0;
    take_dig  = 1'b0;
    if (spec.left_justify) begin
      if (sign_q)              take_sign = 1'b1;
      else if (k_q != '0)      take_dig  = 1'b1;
      else                     take_pad  = 1'b1;
    end else if (spec.zero_pad) begin
      if (sign_q)              take_sign = 1'b1;
      else if (pad_q != '0)    take_pad  = 1'b1;
      else                     take_dig  = 1'b1;
    end else begin
      if (pad_q != '0)         take_pad  = 1'b1;
      else if (sign_q)         take_sign = 1'b1;
      else                     take_dig  = 1'b1;
    end
  end

  assign emit_char = take_sign ? pfi_pkg::CH_MINUS :
                     take_pad  ? pad_char : dig_q[rd_idx];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && cmd.emit_char) begin
          state_d = S_CHR;
        end else if (accept && cmd.convert) begin
          state_d = (cmd.radix == pfi_pkg::RADIX_CHR) ? S_PREP : S_DIG;
        end
      end
      S_CHR: begin
        if (load_ok) state_d = S_IDLE;
      end
      S_DIG: begin
        if (quo == '0 || size_q == CW'(pfi_pkg::DIGIT_BUFFER - 1)) state_d = S_PREP;
      end
      S_PREP: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (done) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          lit_q   <= cmd.lit;
          radix_q <= cmd.radix;
          upper_q <= cmd.upper;
          neg_q   <= cmd.is_signed && argument[15];
          val_q   <= (cmd.is_signed && argument[15]) ? (~argument + 16'd1) : argument;
          size_q  <= (cmd.radix == pfi_pkg::RADIX_CHR) ? CW'(1) : '0;
          if (cmd.radix == pfi_pkg::RADIX_CHR) begin
            dig_q[0] <= argument[7:0];
          end
        end
      end
      S_DIG: begin
        dig_q[size_q[IW-1:0]] <= digit_char;
        val_q                 <= quo;
        size_q                <= size_q + CW'(1);
      end
      S_PREP: begin
        k_q    <= size_q;
        sign_q <= neg_q;
        if (spec.pad_width > size_ext) begin
          pad_q <= spec.pad_width - size_ext - WW'(neg_q);
          rem_q <= spec.pad_width;
        end else begin
          pad_q <= '0;
          rem_q <= size_ext + WW'(neg_q);
        end
      end
      S_EMIT: begin
        if (load_ok) begin
          rem_q <= rem_q - WW'(1);
          if (take_sign) sign_q <= 1'b0;
          if (take_pad)  pad_q  <= pad_q - WW'(1);
          if (take_dig)  k_q    <= k_q - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // output register: loads from CHR or EMIT when the slot is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_ok) begin
      out_valid_q <= (state_q == S_CHR) || (state_q == S_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok && state_q == S_CHR) begin
      out_data_q <= lit_q;
      out_last_q <= 1'b1;
    end else if (load_ok && state_q == S_EMIT) begin
      out_data_q <= emit_char;
      out_last_q <= (rem_q == WW'(1));
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

[src/pfi_checker.sv]
// pfi_checker: port-level assertions for printf_format_interpreter_top.
// Bound to the top level below; depends on pfi_pkg.
module pfi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [23:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // stalled output transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output changed while stalled");

  // no new item while an item's output is incomplete
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input ready in the middle of an output run");

  // a string end returns to idle at once
  a_nul_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tdata_i[7:0] == pfi_pkg::CH_NUL |=>
      s_axis_tready_o)
    else $error("not ready after string end");

  // a string end produces no output
  a_nul_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tdata_i[7:0] == pfi_pkg::CH_NUL &&
      !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("output after string end");

endmodule

bind printf_format_interpreter_top pfi_checker u_pfi_checker (.*);

[bench/tb_printf_format_interpreter_top.sv]
// tb_printf_format_interpreter_top: self-checking bench for the streaming printf formatter.
// Depends on pfi_pkg and printf_format_interpreter_top; a scoreboard class predicts
// every output character from the format bytes that are accepted.
`timescale 1ns / 1ps

module tb_printf_format_interpreter_top;

  localparam int unsigned MAX_WIDTH  = 64;
  localparam int unsigned MAX_CHARS  = 64;    // cap on characters per format byte
  localparam int          N_RANDOM   = 236;
  localparam int          TAIL_CYC   = 80;    // drain time after the last expectation
  localparam int          HOLD_CYC   = 400;   // long receiver hold-off

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_char_t;

  // Scoreboard: tracks the parser state and holds the characters still to come.
  class printf_char_scoreboard;
    logic       in_spec;
    logic       zero_pad;
    logic       digit_seen;
    logic       left_justify;
    logic [6:0] pad_width;
    out_char_t  expected_chars[$];
    out_char_t  step_chars[$];
    int         mismatches;

    function new();
      clear_spec();
      mismatches = 0;
    endfunction

    function void clear_spec();
      in_spec      = 1'b0;
      zero_pad     = 1'b0;
      digit_seen   = 1'b0;
      left_justify = 1'b0;
      pad_width    = '0;
    endfunction

    function void emit(logic [7:0] ch);
      out_char_t oc;
      oc.out_char = ch;
      oc.last     = 1'b0;
      if (step_chars.size() < MAX_CHARS) step_chars.push_back(oc);
    endfunction

    function void emit_pad(int unsigned size, logic neg, logic [7:0] ch);
      int unsigned p;
      if (pad_width > size) begin
        p = pad_width - size;
        if (neg && p > 0) p--;
        repeat (p) emit(ch);
      end
    endfunction

    // Work out the characters one accepted format byte produces.
    function void note_format_item(logic [7:0] ch, logic [15:0] arg);
      logic [7:0]  digits [pfi_pkg::DIGIT_BUFFER];
      int unsigned size;
      int unsigned radix;
      int unsigned v;
      int unsigned d;
      int unsigned w;
      logic        upper;
      logic        neg;
      logic [15:0] mag;
      size  = 0;
      radix = 0;
      upper = 1'b0;
      neg   = 1'b0;
      mag   = arg;
      step_chars.delete();
      if (ch == pfi_pkg::CH_NUL) begin
        clear_spec();
        return;
      end
      if (!in_spec) begin
        if (ch == pfi_pkg::CH_PERCENT) begin
          clear_spec();
          in_spec = 1'b1;
          return;
        end
        emit(ch);
      end else if (ch == pfi_pkg::CH_ZERO && !digit_seen) begin
        zero_pad   = 1'b1;
        digit_seen = 1'b1;
      end else if (ch >= pfi_pkg::CH_ZERO && ch <= pfi_pkg::CH_NINE) begin
        w = pad_width * 10 + (ch - pfi_pkg::CH_ZERO);
        pad_width  = (w > MAX_WIDTH) ? 7'(MAX_WIDTH) : 7'(w);
        digit_seen = 1'b1;
      end else if (ch == pfi_pkg::CH_MINUS) begin
        left_justify = 1'b1;
      end else if (ch == pfi_pkg::CH_PERCENT) begin
        emit(pfi_pkg::CH_PERCENT);
        clear_spec();
      end else begin
        case (ch)
          pfi_pkg::CH_LOWER_D, pfi_pkg::CH_LOWER_I: begin
            radix = 10;
            if (arg[15]) begin
              neg = 1'b1;
              mag = 16'd0 - arg;
            end
          end
          pfi_pkg::CH_LOWER_U: radix = 10;
          pfi_pkg::CH_LOWER_X, pfi_pkg::CH_UPPER_X: begin
            radix = 16;
            upper = (ch == pfi_pkg::CH_UPPER_X);
          end
          pfi_pkg::CH_LOWER_O: radix = 8;
          pfi_pkg::CH_LOWER_C: begin
            digits[0] = arg[7:0];
            size      = 1;
          end
          default: begin
            // unknown conversion: spec ends, nothing out
            clear_spec();
            return;
          end
        endcase
        if (radix != 0) begin
          v = mag;
          do begin
            d = v % radix;
            if (d <= 9) digits[size] = 8'(pfi_pkg::CH_ZERO + d);
            else        digits[size] = 8'((upper ? pfi_pkg::CH_UPPER_A
                                                 : pfi_pkg::CH_LOWER_A) + d - 10);
            size++;
            v = v / radix;
          end while (v != 0 && size < pfi_pkg::DIGIT_BUFFER);
        end
        if (left_justify) begin
          if (neg) emit(pfi_pkg::CH_MINUS);
          for (int k = size - 1; k >= 0; k--) emit(digits[k]);
          emit_pad(size, neg, pfi_pkg::CH_SPACE);
        end else begin
          if (neg && zero_pad) emit(pfi_pkg::CH_MINUS);
          emit_pad(size, neg, zero_pad ? pfi_pkg::CH_ZERO : pfi_pkg::CH_SPACE);
          if (neg && !zero_pad) emit(pfi_pkg::CH_MINUS);
          for (int k = size - 1; k >= 0; k--) emit(digits[k]);
        end
        clear_spec();
      end
      if (step_chars.size() > 0) step_chars[step_chars.size() - 1].last = 1'b1;
      foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
    endfunction

    function void check_out_char(logic [7:0] ch, logic last);
      out_char_t exp_c;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected char %02h last %0b", $realtime, ch, last);
        return;
      end
      exp_c = expected_chars.pop_front();
      if (exp_c.out_char !== ch || exp_c.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: char expected %02h last %0b, got %02h last %0b",
                   $realtime, exp_c.out_char, exp_c.last, ch, last);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;    // format_char[7:0], argument[23:8]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;    // out_char[7:0]
  logic        m_axis_tlast_o;

  printf_char_scoreboard char_sb;
  int  items_sent;
  bit  no_idle;        // phase with no gaps and no stalls
  int  hold_len;       // request for a long receiver hold-off, picked up by the receiver

  logic [7:0] conv_codes [8] = '{pfi_pkg::CH_LOWER_D, pfi_pkg::CH_LOWER_I,
                                 pfi_pkg::CH_LOWER_U, pfi_pkg::CH_LOWER_X,
                                 pfi_pkg::CH_UPPER_X, pfi_pkg::CH_LOWER_O,
                                 pfi_pkg::CH_LOWER_C, pfi_pkg::CH_PERCENT};

  printf_format_interpreter_top #(
    .MAX_WIDTH(MAX_WIDTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one format byte; gap cycles first, then hold valid until the transfer.
  // Valid stays high across back-to-back items, so it gets one assignment per step.
  task automatic send_item(input logic [7:0] ch, input logic [15:0] arg);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {arg, ch};
    do @(posedge clk_i); while (!s_axis_tready_o);
    char_sb.note_format_item(ch, arg);
    items_sent++;
  endtask

  // One conversion spec: '%', optional zero flag, optional '-', width digits, letter.
  // Only the letter carries the real argument; the others get noise.
  task automatic send_spec(input bit zero_flag, input bit minus_flag, input int width,
                           input logic [7:0] conv, input logic [15:0] arg);
    string wtxt;
    send_item(pfi_pkg::CH_PERCENT, 16'($urandom));
    if (zero_flag)  send_item(pfi_pkg::CH_ZERO, 16'($urandom));
    if (minus_flag) send_item(pfi_pkg::CH_MINUS, 16'($urandom));
    if (width > 0) begin
      wtxt = $sformatf("%0d", width);
      for (int i = 0; i < wtxt.len(); i++) send_item(wtxt[i], 16'($urandom));
    end
    send_item(conv, arg);
  endtask

  function automatic logic [15:0] pick_arg();
    logic [15:0] edge_vals [4] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
    if ($urandom_range(0, 3) == 0) return edge_vals[$urandom_range(0, 3)];
    return 16'($urandom);
  endfunction

  function automatic int pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 80) return $urandom_range(1, 9);
    if (r < 95) return $urandom_range(10, 20);
    return $urandom_range(21, 999);   // often saturates
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    int n;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        repeat (n) begin
          @(negedge clk_i);
          m_axis_tready_i <= 1'b0;
        end
      end
      stall = no_idle ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready_i <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      char_sb.check_out_char(m_axis_tdata_o, m_axis_tlast_o);
    end
  end

  // Main stimulus
  initial begin
    int r;
    int k;
    int rand_items;
    char_sb         = new();
    items_sent      = 0;
    no_idle         = 1'b0;
    hold_len        = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes, every conversion, special cases
    send_item(8'hFF, 16'h0000);                                 // plain, top byte value
    send_item(8'h01, 16'hFFFF);
    send_spec(0, 0, 0, pfi_pkg::CH_PERCENT, 16'h0000);          // literal percent
    send_spec(0, 0, 0, pfi_pkg::CH_LOWER_D, 16'h8000);          // most negative value
    send_spec(1, 0, 5, pfi_pkg::CH_LOWER_I, 16'hFFFB);          // zero pad with sign first
    send_spec(0, 1, 6, pfi_pkg::CH_LOWER_U, 16'hFFFF);          // left justify
    send_spec(0, 0, 99, pfi_pkg::CH_UPPER_X, 16'hABCD);         // width saturates
    send_spec(0, 0, 0, pfi_pkg::CH_LOWER_X, 16'h00FF);
    send_spec(0, 0, 0, pfi_pkg::CH_LOWER_O, 16'hFFFF);          // six octal digits
    send_spec(0, 0, 0, pfi_pkg::CH_LOWER_C, 16'h1234);
    send_item(pfi_pkg::CH_PERCENT, 16'h5555);                   // unknown conversion
    send_item(pfi_pkg::CH_SPACE, 16'hAAAA);
    send_item(pfi_pkg::CH_PERCENT, 16'h0000);                   // string end inside a spec
    send_item(8'(pfi_pkg::CH_ZERO + 5), 16'h0000);
    send_item(pfi_pkg::CH_NUL, 16'hFFFF);
    send_item(pfi_pkg::CH_PERCENT, 16'h0000);                   // second zero is a width digit
    send_item(pfi_pkg::CH_ZERO, 16'h0000);
    send_item(pfi_pkg::CH_ZERO, 16'h0000);
    send_item(8'(pfi_pkg::CH_ZERO + 7), 16'h0000);
    send_item(pfi_pkg::CH_LOWER_D, 16'hFFFF);

    // random: mostly well-formed specs, with plain text, broken specs and string ends
    rand_items = 0;
    k = 0;
    while (rand_items < N_RANDOM) begin
      k++;
      no_idle = ((k / 20) % 4 == 3);
      if (k == 40) hold_len = HOLD_CYC;   // sender keeps offering meanwhile
      r = items_sent;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: begin
          send_spec($urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0, pick_width(),
                    ($urandom_range(0, 9) == 0) ? 8'($urandom) : conv_codes[$urandom_range(0, 7)],
                    pick_arg());
        end
        13, 14, 15, 16: begin
          repeat ($urandom_range(1, 4)) send_item(8'($urandom_range(1, 255)), 16'($urandom));
        end
        17, 18: begin
          send_item(pfi_pkg::CH_PERCENT, 16'($urandom));
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 2))
              0: send_item(8'(pfi_pkg::CH_ZERO + $urandom_range(0, 9)), 16'($urandom));
              1: send_item(pfi_pkg::CH_MINUS, 16'($urandom));
              default: send_item(8'($urandom), pick_arg());
            endcase
          end
        end
        default: send_item(pfi_pkg::CH_NUL, 16'($urandom));
      endcase
      rand_items += items_sent - r;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    no_idle = 1'b0;

    while (char_sb.expected_chars.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);
    if (char_sb.mismatches == 0 && char_sb.expected_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, well past the slowest legal run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
